// ===== sv/csr_spmv_pkg.sv =====
// Shared types and constants for the CSR sparse matrix-vector multiply block.
`default_nettype none

package csr_spmv_pkg;

  localparam int VALUE_W   = 16;
  localparam int COLUMN_W  = 12;
  localparam int PROD_W    = 2 * VALUE_W;
  localparam int ACC_W     = 48;
  localparam int ROW_IDX_W = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_NONZERO = 2'd1,
    OP_EMPTY   = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  // One queued work item: a product to accumulate, or an empty-row marker.
  typedef struct packed {
    logic                       empty_row;
    logic                       last;
    logic signed [PROD_W-1:0]   product;
  } queue_entry_t;

endpackage

`default_nettype wire

// ===== sv/csr_sparse_matrix_vector_multiply.sv =====
// Top level of the CSR sparse matrix times dense vector multiplier.
//
//  Channel  Dir  Handshake            Payload
//  input    in   in_valid/in_ready    operation, value, column, last_in_row
//  output   out  out_valid/out_ready  row_index, row_sum, saturated
//
// One transaction per cycle on the input while in_ready is high: loads
// write the vector store on the accepting edge; nonzeros read it, multiply
// in the next cycle and queue the product; the accumulator takes one queued
// entry per cycle while the result register is free. Rows pass the product
// stage, queue and result register. Unused op codes and loads yield nothing.
// Reset clears the accumulator, row counter and queue; the vector store is
// not cleared and must be loaded before use.
// Output stalls back up through the four-entry queue to in_ready.
`default_nettype none

module csr_sparse_matrix_vector_multiply #(
  parameter int VECTOR_DEPTH = 4096,
  parameter int MAX_ROWS     = 65536
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        in_valid,
  output logic                                             in_ready,
  input  wire logic [1:0]                                  operation,
  input  wire logic signed [csr_spmv_pkg::VALUE_W-1:0]     value,
  input  wire logic [csr_spmv_pkg::COLUMN_W-1:0]           column,
  input  wire logic                                        last_in_row,
  output logic                                             out_valid,
  input  wire logic                                        out_ready,
  output logic [csr_spmv_pkg::ROW_IDX_W-1:0]               row_index,
  output logic signed [csr_spmv_pkg::ACC_W-1:0]            row_sum,
  output logic                                             saturated
);

  logic                        push;
  logic                        push_ready;
  csr_spmv_pkg::queue_entry_t  push_entry;
  csr_spmv_pkg::queue_entry_t  head;
  logic                        head_valid;
  logic                        pop;

  // Decode, vector store and multiplier.
  csr_spmv_front #(
    .VECTOR_DEPTH (VECTOR_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .value       (value),
    .column      (column),
    .last_in_row (last_in_row),
    .push        (push),
    .push_entry  (push_entry),
    .queue_ready (push_ready)
  );

  // Products and empty-row markers wait here for the accumulator.
  csr_spmv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // Saturating accumulate and row results.
  csr_spmv_back #(
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .row_index  (row_index),
    .row_sum    (row_sum),
    .saturated  (saturated)
  );

endmodule

`default_nettype wire

// ===== sv/csr_spmv_front.sv =====
// Front end: input handshake, op decode, vector store and product stage.
`default_nettype none

module csr_spmv_front #(
  parameter int VECTOR_DEPTH = 4096
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        in_valid,
  output logic                                             in_ready,
  input  wire logic [1:0]                                  operation,
  input  wire logic signed [csr_spmv_pkg::VALUE_W-1:0]     value,
  input  wire logic [csr_spmv_pkg::COLUMN_W-1:0]           column,
  input  wire logic                                        last_in_row,
  output logic                                             push,
  output csr_spmv_pkg::queue_entry_t                       push_entry,
  input  wire logic                                        queue_ready
);

  localparam int AW = $clog2(VECTOR_DEPTH);

  logic signed [csr_spmv_pkg::VALUE_W-1:0] mem [VECTOR_DEPTH];
  logic signed [csr_spmv_pkg::VALUE_W-1:0] rdata;

  logic                                    s1_valid;
  logic                                    s1_empty;
  logic                                    s1_last;
  logic                                    s1_in_range;
  logic signed [csr_spmv_pkg::VALUE_W-1:0] s1_value;

  csr_spmv_pkg::op_t                       op;
  logic                                    accept;
  logic                                    in_range;
  logic [AW-1:0]                           addr;
  logic signed [csr_spmv_pkg::VALUE_W-1:0] xv;

  assign op       = csr_spmv_pkg::op_t'(operation);
  assign in_ready = !s1_valid || queue_ready;
  assign accept   = in_valid && in_ready;
  assign in_range = 32'(column) < 32'(VECTOR_DEPTH);
  assign addr     = AW'(column);

  // Vector store; a load followed at once by a read of the same entry
  // sees the new value, as the write lands on the load's own accepting edge.
  always_ff @(posedge clk) begin
    if (accept && op == csr_spmv_pkg::OP_LOAD && in_range) begin
      mem[addr] <= value;
    end
    if (accept && op == csr_spmv_pkg::OP_NONZERO) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= accept &&
                  (op == csr_spmv_pkg::OP_NONZERO || op == csr_spmv_pkg::OP_EMPTY);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_empty    <= (op == csr_spmv_pkg::OP_EMPTY);
      s1_last     <= last_in_row;
      s1_in_range <= in_range;
      s1_value    <= value;
    end
  end

  assign xv = s1_in_range ? rdata : '0;

  always_comb begin
    push                 = s1_valid && queue_ready;
    push_entry.empty_row = s1_empty;
    push_entry.last      = s1_last;
    push_entry.product   = s1_value * xv;
  end

endmodule

`default_nettype wire

// ===== sv/csr_spmv_queue.sv =====
// Short queue decoupling the product stage from the accumulator.
`default_nettype none

module csr_spmv_queue (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire csr_spmv_pkg::queue_entry_t   push_entry,
  output logic                              push_ready,
  input  wire logic                         pop,
  output csr_spmv_pkg::queue_entry_t        head,
  output logic                              head_valid
);

  csr_spmv_pkg::queue_entry_t           entries [csr_spmv_pkg::QUEUE_DEPTH];
  logic [csr_spmv_pkg::QUEUE_AW-1:0]    wr_ptr;
  logic [csr_spmv_pkg::QUEUE_AW-1:0]    rd_ptr;
  logic [csr_spmv_pkg::QUEUE_AW:0]      count;
  logic                                 do_push;
  logic                                 do_pop;

  assign push_ready = count != (csr_spmv_pkg::QUEUE_AW + 1)'(csr_spmv_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/csr_spmv_back.sv =====
// Back end: saturating accumulator, row counter and result register.
`default_nettype none

module csr_spmv_back #(
  parameter int MAX_ROWS = 65536
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire csr_spmv_pkg::queue_entry_t                  head,
  input  wire logic                                        head_valid,
  output logic                                             pop,
  output logic                                             out_valid,
  input  wire logic                                        out_ready,
  output logic [csr_spmv_pkg::ROW_IDX_W-1:0]               row_index,
  output logic signed [csr_spmv_pkg::ACC_W-1:0]            row_sum,
  output logic                                             saturated
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int AW = csr_spmv_pkg::ACC_W;
  localparam int PW = csr_spmv_pkg::PROD_W;

  logic signed [AW-1:0] acc;
  logic                 overflow_seen;
  logic [RW-1:0]        row_counter;
  logic [RW-1:0]        row_counter_next;

  logic signed [AW:0]   sum_wide;
  logic                 sum_ovf;
  logic signed [AW-1:0] sum_sat;
  logic                 emit;

  assign pop  = head_valid && (!out_valid || out_ready);
  assign emit = pop && (head.empty_row || head.last);

  always_comb begin
    sum_wide = {acc[AW-1], acc} + {{(AW + 1 - PW){head.product[PW-1]}}, head.product};
    sum_ovf  = sum_wide[AW] != sum_wide[AW-1];
    if (sum_ovf) begin
      sum_sat = sum_wide[AW] ? csr_spmv_pkg::ACC_MIN : csr_spmv_pkg::ACC_MAX;
    end else begin
      sum_sat = sum_wide[AW-1:0];
    end
    row_counter_next = (row_counter == RW'(MAX_ROWS - 1)) ? '0 : row_counter + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc           <= '0;
      overflow_seen <= 1'b0;
      row_counter   <= '0;
    end else if (pop) begin
      if (!head.empty_row) begin
        if (head.last) begin
          acc           <= '0;
          overflow_seen <= 1'b0;
        end else begin
          acc           <= sum_sat;
          overflow_seen <= overflow_seen || sum_ovf;
        end
      end
      if (emit) begin
        row_counter <= row_counter_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      row_index <= csr_spmv_pkg::ROW_IDX_W'(row_counter);
      if (head.empty_row) begin
        row_sum   <= '0;
        saturated <= 1'b0;
      end else begin
        row_sum   <= sum_sat;
        saturated <= overflow_seen || sum_ovf;
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_csr_sparse_matrix_vector_multiply.sv =====
// Self-checking testbench for the CSR sparse matrix-vector multiplier.
`default_nettype none

module tb_csr_sparse_matrix_vector_multiply;
  timeunit 1ns;
  timeprecision 1ps;

  import csr_spmv_pkg::*;

  // Backlog kept in the pending queue; the stimulus process tops it up.
  localparam int BACKLOG     = 64;
  // Length of the long output hold-off that forces the block to stall its input.
  localparam int HOLD_CYCLES = 200;
  // Settle time after the last row.
  localparam int TAIL_CYCLES = 12;

  typedef struct {
    op_t                        op;
    logic signed [VALUE_W-1:0]  value;
    logic [COLUMN_W-1:0]        column;
    logic                       last;
  } spmv_item_t;

  typedef struct packed {
    logic [ROW_IDX_W-1:0]       row_index;
    logic signed [ACC_W-1:0]    row_sum;
    logic                       saturated;
  } row_result_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT pins
  // ---------------------------------------------------------------------------
  logic clk;
  logic rst = 1'b1;

  logic                        in_valid    = 1'b0;
  logic                        in_ready;
  logic [1:0]                  operation   = OP_UNUSED;
  logic signed [VALUE_W-1:0]   value       = '0;
  logic [COLUMN_W-1:0]         column      = '0;
  logic                        last_in_row = 1'b0;
  logic                        out_valid;
  logic                        out_ready   = 1'b0;
  logic [ROW_IDX_W-1:0]        row_index;
  logic signed [ACC_W-1:0]     row_sum;
  logic                        saturated;

  csr_sparse_matrix_vector_multiply DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .value       (value),
    .column      (column),
    .last_in_row (last_in_row),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .row_index   (row_index),
    .row_sum     (row_sum),
    .saturated   (saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Testbench state
  // ---------------------------------------------------------------------------
  spmv_item_t          pending[$];      // items waiting for the driver
  row_result_t         rows_due[$];     // predicted rows, oldest first
  logic [COLUMN_W-1:0] loaded_cols[$];  // columns written so far (nonzeros use only these)

  int unsigned src_idle_pct   = 0;      // chance per cycle the sender sits idle
  int unsigned sink_stall_pct = 0;      // chance per cycle the receiver stalls
  logic        sink_hold      = 1'b0;   // long receiver hold-off
  logic        hold_start     = 1'b0;

  int unsigned stim_count     = 0;      // items queued, unused op codes excluded
  int unsigned items_accepted = 0;
  int unsigned rows_checked   = 0;
  int unsigned fail_count     = 0;

  // Predictor state: own copy of the vector store, accumulator, row counter
  // and the sticky saturation flag.
  bit signed [VALUE_W-1:0]   x_copy [4096];
  logic signed [ACC_W-1:0]   acc_model = '0;
  logic [ROW_IDX_W-1:0]      row_model = '0;
  logic                      sat_model = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor: advance the model by one accepted transaction and queue the
  // row it finishes, if any.
  // ---------------------------------------------------------------------------
  task automatic spmv_apply(input op_t op, input logic signed [VALUE_W-1:0] v,
                            input logic [COLUMN_W-1:0] c, input logic last);
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W:0]    sum;
    row_result_t              r;
    case (op)
      // 12-bit column never reaches past a 4096-entry store
      OP_LOAD: x_copy[c] = v;
      OP_NONZERO: begin
        prod = v * x_copy[c];
        sum  = acc_model + prod;
        if (sum > ACC_MAX) begin
          sum       = ACC_MAX;
          sat_model = 1'b1;
        end else if (sum < ACC_MIN) begin
          sum       = ACC_MIN;
          sat_model = 1'b1;
        end
        acc_model = sum[ACC_W-1:0];
        if (last) begin
          r.row_index = row_model;
          r.row_sum   = acc_model;
          r.saturated = sat_model;
          rows_due.push_back(r);
          row_model = row_model + 1'b1;  // wraps at 2^16 = MAX_ROWS
          acc_model = '0;
          sat_model = 1'b0;
        end
      end
      // empty row: zero sum, flag clear, any partial sum carried over untouched
      OP_EMPTY: begin
        r.row_index = row_model;
        r.row_sum   = '0;
        r.saturated = 1'b0;
        rows_due.push_back(r);
        row_model = row_model + 1'b1;
      end
      default: ;  // unused code: ignored
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents pending items; valid stays up with a steady payload until
  // the transaction completes, then the next item follows in the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    spmv_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        it = pending.pop_front();
        operation   <= it.op;
        value       <= it.value;
        column      <= it.column;
        last_in_row <= it.last;
        in_valid    <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure: random stalls plus the long hold-off.
  always @(posedge clk) begin
    out_ready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
  end

  // Long hold-off, counted in its own process once requested.
  initial begin : hold_off
    wait (hold_start);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    sink_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each output transaction against the oldest predicted row,
  // then feeds the accepted input transaction to the predictor.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    row_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (rows_due.size() == 0) begin
          $error("unexpected row: row_index %0d row_sum %0d saturated %0b",
                 row_index, row_sum, saturated);
          fail_count++;
        end else begin
          want = rows_due.pop_front();
          rows_checked++;
          if (row_index !== want.row_index) begin
            $error("row_index: expected %0d, got %0d", want.row_index, row_index);
            fail_count++;
          end
          if (row_sum !== want.row_sum) begin
            $error("row_sum: expected %0d, got %0d", want.row_sum, row_sum);
            fail_count++;
          end
          if (saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, saturated);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        items_accepted++;
        spmv_apply(op_t'(operation), value, column, last_in_row);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_item(input op_t op, input logic signed [VALUE_W-1:0] v,
                           input logic [COLUMN_W-1:0] c, input logic last);
    spmv_item_t it;
    while (pending.size() >= BACKLOG) @(negedge clk);
    it.op     = op;
    it.value  = v;
    it.column = c;
    it.last   = last;
    pending.push_back(it);
    if (op == OP_LOAD) loaded_cols.push_back(c);
    if (op != OP_UNUSED) stim_count++;
  endtask

  // Mostly random, with the extremes and all-ones pattern turning up often.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return -16'sd1;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // Only columns already loaded are read, so no stale store entry is touched.
  function automatic logic [COLUMN_W-1:0] pick_loaded_col();
    return loaded_cols[$urandom_range(loaded_cols.size() - 1)];
  endfunction

  // One random sequence: mostly complete rows, some loads, empty rows,
  // rows broken off by an empty row, and unused op codes as noise.
  task automatic push_random_sequence();
    int unsigned r;
    int unsigned n;
    logic [COLUMN_W-1:0] c;
    r = $urandom_range(99);
    if (r < 12) begin
      case ($urandom_range(3))
        0:       c = '0;
        1:       c = '1;
        default: c = COLUMN_W'($urandom);
      endcase
      push_item(OP_LOAD, pick_value(), c, 1'($urandom_range(1)));
    end else if (r < 72) begin
      n = (r < 66) ? $urandom_range(1, 5) : $urandom_range(8, 20);
      for (int i = 0; i < n; i++)
        push_item(OP_NONZERO, pick_value(), pick_loaded_col(), i == n - 1);
    end else if (r < 82) begin
      push_item(OP_EMPTY, pick_value(), COLUMN_W'($urandom), 1'($urandom_range(1)));
    end else if (r < 92) begin
      // partial row interrupted by an empty row; the sum carries on
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
        push_item(OP_NONZERO, pick_value(), pick_loaded_col(), 1'b0);
      push_item(OP_EMPTY, pick_value(), COLUMN_W'($urandom), 1'($urandom_range(1)));
      push_item(OP_NONZERO, pick_value(), pick_loaded_col(), 1'b1);
    end else begin
      push_item(OP_UNUSED, pick_value(), COLUMN_W'($urandom), 1'($urandom_range(1)));
    end
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned start;
    start = stim_count;
    while (stim_count - start < n) push_random_sequence();
  endtask

  // Sender pauses until every predicted row has been seen.
  task automatic drain_rows();
    while (pending.size() != 0 || in_valid || rows_due.size() != 0) @(negedge clk);
  endtask

  function automatic int unsigned pick_pct();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 50;
      default: return 85;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: field extremes, every op code, and the special cases.
    push_item(OP_LOAD, 16'sh7FFF, 12'd0, 1'b1);       // last flag ignored on loads
    push_item(OP_LOAD, 16'sh8000, 12'd4095, 1'b0);
    push_item(OP_LOAD, -16'sd1, 12'd1, 1'b0);
    push_item(OP_LOAD, 16'sh5A5A, 12'd2, 1'b0);
    push_item(OP_LOAD, 16'sd0, 12'd3, 1'b0);
    push_item(OP_UNUSED, -16'sd1, 12'd4095, 1'b1);    // unused code, no row
    push_item(OP_NONZERO, 16'sh8000, 12'd0, 1'b0);    // not last: accumulate only
    push_item(OP_NONZERO, 16'sh7FFF, 12'd4095, 1'b0);
    push_item(OP_NONZERO, -16'sd1, 12'd1, 1'b1);
    push_item(OP_EMPTY, 16'sh7FFF, 12'd4095, 1'b0);
    push_item(OP_EMPTY, 16'sh8000, 12'd0, 1'b1);
    push_item(OP_NONZERO, 16'sd12345, 12'd3, 1'b1);   // zero vector entry
    push_item(OP_NONZERO, 16'sd0, 12'd2, 1'b1);       // zero matrix value
    push_item(OP_NONZERO, 16'sh7FFF, 12'd0, 1'b0);    // partial sum ...
    push_item(OP_EMPTY, 16'sd0, 12'd0, 1'b0);         // ... survives an empty row
    push_item(OP_NONZERO, 16'sh8000, 12'd4095, 1'b1);
    push_item(OP_NONZERO, 16'sh8000, 12'd4095, 1'b1); // largest positive product
    drain_rows();

    // Random phases across the idling patterns.
    run_random(130);
    drain_rows();
    src_idle_pct = 85;
    run_random(130);
    drain_rows();
    src_idle_pct   = 0;
    sink_stall_pct = 85;
    run_random(130);
    drain_rows();
    src_idle_pct   = 27;
    sink_stall_pct = 27;
    run_random(130);
    drain_rows();

    // Long receiver hold-off with the sender flat out: the product queue
    // fills and in_ready must drop until the receiver returns.
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_start     = 1'b1;
    for (int i = 0; i < 48; i++) begin
      if (i % 3 == 0)
        push_item(OP_EMPTY, pick_value(), COLUMN_W'($urandom), 1'($urandom_range(1)));
      else
        push_item(OP_NONZERO, pick_value(), pick_loaded_col(), 1'b1);
    end
    drain_rows();

    // Mixed stretches, some with no idling at all.
    for (int k = 0; k < 5; k++) begin
      src_idle_pct   = pick_pct();
      sink_stall_pct = pick_pct();
      run_random(25);
      while (pending.size() != 0) @(negedge clk);
    end
    drain_rows();

    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Accepted %0d transactions over four idling patterns, a long output",
             items_accepted);
    $display("hold-off and mixed stretches; checked %0d rows incl. empty and broken rows.",
             rows_checked);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: several times the slowest expected run.
  initial begin : watchdog
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/csr_spmv_pkg.sv
sv/csr_spmv_front.sv
sv/csr_spmv_queue.sv
sv/csr_spmv_back.sv
sv/csr_sparse_matrix_vector_multiply.sv
tb/tb_csr_sparse_matrix_vector_multiply.sv
